FILE: rtl/dbrgb_pkg.sv
package dbrgb_pkg;

   // field widths
   localparam int LEVEL_W  = 16;
   localparam int MAG_W    = 17;   // magnitude of the most negative level needs one more bit
   localparam int FLOOR_W  = 9;
   localparam int COLOUR_W = 8;

   // colour table geometry
   localparam int MAP_ENTRIES = 19;
   localparam int MAP_LAST    = MAP_ENTRIES - 1;
   localparam int IDX_W       = 5;
   localparam int IDX_STEPS   = IDX_W;      // one quotient bit per stage
   localparam int CHAN_STEPS  = COLOUR_W;   // interpolated channel is below 256

   localparam int DB_FRAC_BITS_DEF = 7;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_FLOOR_DB = 1'b0;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = 9'h1A6;   // -90 dB

   // pipeline depth
   localparam int INTERP_STAGES = CHAN_STEPS + 2;
   localparam int PIPE_LATENCY  = 1 + IDX_STEPS + 1 + INTERP_STAGES + 1;

   localparam logic [COLOUR_W-1:0] CHAN_FULL  = 8'hFF;
   localparam logic [COLOUR_W-1:0] CHAN_EMPTY = 8'h00;

   typedef struct packed {
      logic valid;
      logic white;
      logic black;
   } flags_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } rgb_type;

   function automatic rgb_type colour_rom(input logic [IDX_W-1:0] idx);
      rgb_type c;
      unique case (idx)
         5'd0:    c = '{8'd255, 8'd255, 8'd255};
         5'd1:    c = '{8'd240, 8'd254, 8'd216};
         5'd2:    c = '{8'd242, 8'd251, 8'd185};
         5'd3:    c = '{8'd253, 8'd245, 8'd143};
         5'd4:    c = '{8'd253, 8'd200, 8'd102};
         5'd5:    c = '{8'd252, 8'd144, 8'd66};
         5'd6:    c = '{8'd252, 8'd75,  8'd32};
         5'd7:    c = '{8'd237, 8'd28,  8'd41};
         5'd8:    c = '{8'd214, 8'd3,   8'd64};
         5'd9:    c = '{8'd183, 8'd3,   8'd101};
         5'd10:   c = '{8'd157, 8'd3,   8'd122};
         5'd11:   c = '{8'd122, 8'd3,   8'd126};
         5'd12:   c = '{8'd80,  8'd2,   8'd110};
         5'd13:   c = '{8'd45,  8'd2,   8'd89};
         5'd14:   c = '{8'd19,  8'd2,   8'd70};
         5'd15:   c = '{8'd1,   8'd3,   8'd53};
         5'd16:   c = '{8'd1,   8'd3,   8'd37};
         5'd17:   c = '{8'd1,   8'd2,   8'd19};
         default: c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/dbrgb_interp.sv
module dbrgb_interp import dbrgb_pkg::*; #(
   parameter int DB_FRAC_BITS = DB_FRAC_BITS_DEF,
   localparam int DEN_W = FLOOR_W + DB_FRAC_BITS
) (
   input  logic                clock,
   input  logic [COLOUR_W-1:0] lo_val,
   input  logic [COLOUR_W-1:0] hi_val,
   input  logic [DEN_W-1:0]    den,
   input  logic [DEN_W-1:0]    rem,
   output logic [COLOUR_W-1:0] chan
);

   localparam int NW = DEN_W + COLOUR_W;

   logic [NW-1:0] prod_lo_ff, prod_lo_in;
   logic [NW-1:0] prod_hi_ff, prod_hi_in;
   logic [NW-1:0] numer_ff, numer_in;

   logic [NW-1:0]       step_rem_ff [CHAN_STEPS];
   logic [NW-1:0]       step_rem_in [CHAN_STEPS];
   logic [COLOUR_W-1:0] step_q_ff   [CHAN_STEPS];
   logic [COLOUR_W-1:0] step_q_in   [CHAN_STEPS];

   // weights of the two neighboring entries
   assign prod_lo_in = NW'(lo_val) * NW'(den - rem);
   assign prod_hi_in = NW'(hi_val) * NW'(rem);

   // half the divisor for round to nearest, ties up
   assign numer_in = prod_lo_ff + prod_hi_ff + NW'(den >> 1);

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      numer_ff   <= numer_in;
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar s = 0; s < CHAN_STEPS; s++) begin : g_step
      logic [NW-1:0]       src_rem;
      logic [COLOUR_W-1:0] src_q;
      logic [NW-1:0]       sub;

      if (s == 0) begin : g_first
         assign src_rem = numer_ff;
         assign src_q   = '0;
      end else begin : g_next
         assign src_rem = step_rem_ff[s-1];
         assign src_q   = step_q_ff[s-1];
      end

      assign sub = NW'(den) << (CHAN_STEPS - 1 - s);

      always_comb begin
         if (src_rem >= sub) begin
            step_rem_in[s] = src_rem - sub;
            step_q_in[s]   = src_q | (COLOUR_W'(1) << (CHAN_STEPS - 1 - s));
         end else begin
            step_rem_in[s] = src_rem;
            step_q_in[s]   = src_q;
         end
      end

      always_ff @(posedge clock) begin
         step_rem_ff[s] <= step_rem_in[s];
         step_q_ff[s]   <= step_q_in[s];
      end
   end

   assign chan = step_q_ff[CHAN_STEPS-1];

endmodule

FILE: rtl/db_to_rgb_colour_map.sv
// pipeline: a request accepted at one clock edge gives its pixel on the strobe after
//    1 input stage, 5 index steps, 1 rom stage, 10 interpolation stages and 1 output
//    stage; busy stays low and a request can enter every cycle
// throughput: one pixel per cycle, set by the fully pipelined one-bit-per-stage dividers
// reset: synchronous, clears the valid bits in flight and loads floor_db with -90 dB
// the receiver cannot stall: each pixel is shown for exactly one cycle
module db_to_rgb_colour_map import dbrgb_pkg::*; #(
   parameter int DB_FRAC_BITS = DB_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,

   // request channel
   input  logic                       start,
   output logic                       busy,
   input  logic signed [LEVEL_W-1:0]  req_level_db,

   // pixel channel
   output logic                       rsp_valid,
   output logic [COLOUR_W-1:0]        rsp_red,
   output logic [COLOUR_W-1:0]        rsp_green,
   output logic [COLOUR_W-1:0]        rsp_blue,

   // register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int DEN_W = FLOOR_W + DB_FRAC_BITS;
   // room for |level| * 18 and for the divisor shifted by the top index bit
   localparam int NUM_W = (DEN_W > MAG_W) ? DEN_W + IDX_W : MAG_W + IDX_W;

   // ---------------------------------------------------------------------------------
   // floor register
   // ---------------------------------------------------------------------------------
   logic [FLOOR_W-1:0] floor_ff, floor_in;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      floor_in = floor_ff;
      if (csr_write && (paddr[2] == REG_FLOOR_DB)) begin
         floor_in = pwdata[FLOOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
      end else begin
         floor_ff <= floor_in;
      end
   end

   // read back sign extended, nothing lives above the floor register
   assign prdata = (paddr[2] == REG_FLOOR_DB)
                 ? {{(CSR_DATA_W-FLOOR_W){floor_ff[FLOOR_W-1]}}, floor_ff}
                 : '0;

   // only the magnitude of the floor counts; -256 still fits in nine unsigned bits
   logic [FLOOR_W-1:0] floor_mag;
   logic [DEN_W-1:0]   den;

   assign floor_mag = floor_ff[FLOOR_W-1] ? (FLOOR_W'(0) - floor_ff) : floor_ff;
   assign den       = DEN_W'(floor_mag) << DB_FRAC_BITS;

   // ---------------------------------------------------------------------------------
   // input stage: magnitude, scaling and the white / black decisions
   // ---------------------------------------------------------------------------------
   logic                 accept;
   logic [MAG_W-1:0]     lvl_mag;
   flags_type            flg_a_ff, flg_a_in;
   logic [NUM_W-1:0]     num_a_ff, num_a_in;

   assign busy   = 1'b0;      // every stage advances each cycle
   assign accept = start && !busy;

   // sign extend before negating so the most negative level keeps its magnitude
   assign lvl_mag = MAG_W'(0) - {req_level_db[LEVEL_W-1], req_level_db};

   always_comb begin
      flg_a_in.valid = accept;
      flg_a_in.white = !req_level_db[LEVEL_W-1];
      // position >= last entry exactly when |level| >= den; a zero floor lands here too
      flg_a_in.black = NUM_W'(lvl_mag) >= NUM_W'(den);
      num_a_in       = NUM_W'(lvl_mag) * NUM_W'(MAP_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flg_a_ff <= '0;
      end else begin
         flg_a_ff <= flg_a_in;
      end
      num_a_ff <= num_a_in;
   end

   // ---------------------------------------------------------------------------------
   // table index: restoring division of the scaled level by den, one bit per stage
   // ---------------------------------------------------------------------------------
   flags_type          step_flg_ff [IDX_STEPS];
   logic [NUM_W-1:0]   step_rem_ff [IDX_STEPS];
   logic [NUM_W-1:0]   step_rem_in [IDX_STEPS];
   logic [IDX_W-1:0]   step_q_ff   [IDX_STEPS];
   logic [IDX_W-1:0]   step_q_in   [IDX_STEPS];

   for (genvar s = 0; s < IDX_STEPS; s++) begin : g_idx
      flags_type        src_flg;
      logic [NUM_W-1:0] src_rem;
      logic [IDX_W-1:0] src_q;
      logic [NUM_W-1:0] sub;

      if (s == 0) begin : g_first
         assign src_flg = flg_a_ff;
         assign src_rem = num_a_ff;
         assign src_q   = '0;
      end else begin : g_next
         assign src_flg = step_flg_ff[s-1];
         assign src_rem = step_rem_ff[s-1];
         assign src_q   = step_q_ff[s-1];
      end

      assign sub = NUM_W'(den) << (IDX_STEPS - 1 - s);

      always_comb begin
         if (src_rem >= sub) begin
            step_rem_in[s] = src_rem - sub;
            step_q_in[s]   = src_q | (IDX_W'(1) << (IDX_STEPS - 1 - s));
         end else begin
            step_rem_in[s] = src_rem;
            step_q_in[s]   = src_q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            step_flg_ff[s] <= '0;
         end else begin
            step_flg_ff[s] <= src_flg;
         end
         step_rem_ff[s] <= step_rem_in[s];
         step_q_ff[s]   <= step_q_in[s];
      end
   end

   // ---------------------------------------------------------------------------------
   // rom stage: fetch the two neighboring entries
   // ---------------------------------------------------------------------------------
   logic [IDX_W-1:0]  idx_last;
   flags_type         flg_r_ff;
   logic [IDX_W-1:0]  idx_r_ff;
   logic [DEN_W-1:0]  rem_r_ff;
   rgb_type           lo_r_ff, lo_r_in;
   rgb_type           hi_r_ff, hi_r_in;

   assign idx_last = step_q_ff[IDX_STEPS-1];
   // past the table on black positions; the rom output is then unused and the output overrides
   assign lo_r_in  = colour_rom(idx_last);
   assign hi_r_in  = colour_rom(idx_last + IDX_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         flg_r_ff <= '0;
      end else begin
         flg_r_ff <= step_flg_ff[IDX_STEPS-1];
      end
      idx_r_ff <= idx_last;
      rem_r_ff <= DEN_W'(step_rem_ff[IDX_STEPS-1]);
      lo_r_ff  <= lo_r_in;
      hi_r_ff  <= hi_r_in;
   end

   // ---------------------------------------------------------------------------------
   // per channel interpolation and rounding divide
   // ---------------------------------------------------------------------------------
   rgb_type interp_rgb;

   dbrgb_interp #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_interp_red (
      .clock  (clock),
      .lo_val (lo_r_ff.red),
      .hi_val (hi_r_ff.red),
      .den    (den),
      .rem    (rem_r_ff),
      .chan   (interp_rgb.red)
   );

   dbrgb_interp #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_interp_green (
      .clock  (clock),
      .lo_val (lo_r_ff.green),
      .hi_val (hi_r_ff.green),
      .den    (den),
      .rem    (rem_r_ff),
      .chan   (interp_rgb.green)
   );

   dbrgb_interp #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_interp_blue (
      .clock  (clock),
      .lo_val (lo_r_ff.blue),
      .hi_val (hi_r_ff.blue),
      .den    (den),
      .rem    (rem_r_ff),
      .chan   (interp_rgb.blue)
   );

   // flags ride alongside the interpolation stages
   flags_type dly_flg_ff [INTERP_STAGES];

   for (genvar i = 0; i < INTERP_STAGES; i++) begin : g_dly
      flags_type src_flg;

      if (i == 0) begin : g_first
         assign src_flg = flg_r_ff;
      end else begin : g_next
         assign src_flg = dly_flg_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dly_flg_ff[i] <= '0;
         end else begin
            dly_flg_ff[i] <= src_flg;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // output stage: white and black override the interpolated pixel
   // ---------------------------------------------------------------------------------
   flags_type flg_end;
   logic      rsp_valid_ff;
   rgb_type   rsp_rgb_ff, rsp_rgb_in;

   assign flg_end = dly_flg_ff[INTERP_STAGES-1];

   always_comb begin
      priority if (flg_end.white) begin
         rsp_rgb_in = '{CHAN_FULL, CHAN_FULL, CHAN_FULL};
      end else if (flg_end.black) begin
         rsp_rgb_in = '{CHAN_EMPTY, CHAN_EMPTY, CHAN_EMPTY};
      end else begin
         rsp_rgb_in = interp_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= flg_end.valid;
      end
      rsp_rgb_ff <= rsp_rgb_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_rgb_ff.red;
   assign rsp_green = rsp_rgb_ff.green;
   assign rsp_blue  = rsp_rgb_ff.blue;

   // ---------------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------------

   // every request gives a pixel after the full pipeline depth
   a_request_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      start |-> ##PIPE_LATENCY rsp_valid)
      else $error("request lost in pipeline");

   // no pixel without a request at the matching depth
   a_pixel_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_LATENCY))
      else $error("pixel without request");

   // a level of zero or above comes out white
   a_white_level: assert property (@(posedge clock) disable iff (reset)
      (start && !req_level_db[LEVEL_W-1]) |-> ##PIPE_LATENCY
         (rsp_valid && (rsp_red == CHAN_FULL) && (rsp_green == CHAN_FULL)
          && (rsp_blue == CHAN_FULL)))
      else $error("non-negative level not white");

   // an interpolated position always lands inside the table
   a_index_in_table: assert property (@(posedge clock) disable iff (reset)
      (flg_r_ff.valid && !flg_r_ff.white && !flg_r_ff.black)
         |-> (idx_r_ff < IDX_W'(MAP_LAST)))
      else $error("table index out of range");

   // remainder of the index divide stays below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (flg_r_ff.valid && !flg_r_ff.white && !flg_r_ff.black) |-> (rem_r_ff < den))
      else $error("index remainder not reduced");

endmodule

FILE: tb/sv/tb_db_to_rgb_colour_map.sv
module tb_db_to_rgb_colour_map;
   import dbrgb_pkg::*;

   localparam int FRAC = DB_FRAC_BITS_DEF;

   // one request in flight: the level, the floor it was mapped with, the pixel it must give
   typedef struct {
      logic [LEVEL_W-1:0] level;
      logic [FLOOR_W-1:0] floor_v;
      rgb_type            px;
   } pixel_due_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [LEVEL_W-1:0]    req_level_db = '0;
   logic                  rsp_valid;
   logic [COLOUR_W-1:0]   rsp_red;
   logic [COLOUR_W-1:0]   rsp_green;
   logic [COLOUR_W-1:0]   rsp_blue;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // levels waiting to be sent, pixels waiting to come back
   logic [LEVEL_W-1:0] level_backlog [$];
   pixel_due_type      pixel_due [$];

   // floor currently held by the block, tracked on our side
   logic [FLOOR_W-1:0] floor_setting = FLOOR_RESET;
   int                 send_idle_pct = 0;
   int                 mismatch_count = 0;
   int                 sent_count = 0;
   int                 checked_count = 0;
   int                 floor_writes = 0;

   // the 19-step spectrogram palette, from full white down to black
   int unsigned palette [MAP_ENTRIES][3] = '{
      '{255, 255, 255}, '{240, 254, 216}, '{242, 251, 185}, '{253, 245, 143},
      '{253, 200, 102}, '{252, 144,  66}, '{252,  75,  32}, '{237,  28,  41},
      '{214,   3,  64}, '{183,   3, 101}, '{157,   3, 122}, '{122,   3, 126},
      '{ 80,   2, 110}, '{ 45,   2,  89}, '{ 19,   2,  70}, '{  1,   3,  53},
      '{  1,   3,  37}, '{  1,   2,  19}, '{  0,   0,   0}
   };

   db_to_rgb_colour_map #(
      .DB_FRAC_BITS(FRAC)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_level_db (req_level_db),
      .rsp_valid    (rsp_valid),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // pixel for one level under one floor, exact rational interpolation
   function automatic rgb_type map_level_to_rgb(logic [LEVEL_W-1:0] lv,
                                                logic [FLOOR_W-1:0] fv);
      int unsigned lmag;
      int unsigned fmag;
      int unsigned num;
      int unsigned den;
      int unsigned idx;
      int unsigned rem;
      int unsigned v;
      int unsigned chan [3];
      rgb_type     px;
      // non-negative level saturates to white
      if (!lv[LEVEL_W-1]) begin
         px.red   = CHAN_FULL;
         px.green = CHAN_FULL;
         px.blue  = CHAN_FULL;
         return px;
      end
      px.red   = CHAN_EMPTY;
      px.green = CHAN_EMPTY;
      px.blue  = CHAN_EMPTY;
      // magnitude of the level, -32768 taken as 32768 exactly
      lmag = 32'h10000 - lv;
      // only the floor magnitude matters, so +F behaves as -F
      fmag = fv[FLOOR_W-1] ? (32'h200 - fv) : fv;
      // zero floor gives no spread at all: everything below 0 dB is black
      if (fmag == 0)
         return px;
      num = lmag * MAP_LAST;
      den = fmag << FRAC;
      idx = num / den;
      rem = num % den;
      // at or past the last palette entry
      if (idx >= MAP_LAST)
         return px;
      for (int c = 0; c < 3; c++) begin
         v = (palette[idx][c] * (den - rem) + palette[idx + 1][c] * rem + den / 2) / den;
         chan[c] = (v > 255) ? 255 : v;
      end
      px.red   = chan[0][COLOUR_W-1:0];
      px.green = chan[1][COLOUR_W-1:0];
      px.blue  = chan[2][COLOUR_W-1:0];
      return px;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < 40)
         $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_channel(string chan, logic [COLOUR_W-1:0] got,
                                logic [COLOUR_W-1:0] wanted, pixel_due_type due);
      if (got !== wanted)
         report_mismatch($sformatf("level %0d floor %0d: %s got %0d want %0d",
                                   $signed(due.level), $signed(due.floor_v), chan,
                                   got, wanted));
   endtask

   // request driver: one level per accepted edge, random gaps set by send_idle_pct
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // held off: keep the same request up
      end else begin
         if (start) begin
            pixel_due.push_back(pixel_due_type'{level: req_level_db, floor_v: floor_setting,
                                px: map_level_to_rgb(req_level_db, floor_setting)});
            void'(level_backlog.pop_front());
            sent_count++;
         end
         if (level_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            start        <= 1'b1;
            req_level_db <= level_backlog[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // pixel monitor: every strobe must match the oldest outstanding request
   always @(posedge clock) begin : pixel_monitor
      pixel_due_type due;
      if (!reset && rsp_valid) begin
         if (pixel_due.size() == 0) begin
            report_mismatch($sformatf("pixel %0d/%0d/%0d with no request outstanding",
                                      rsp_red, rsp_green, rsp_blue));
         end else begin
            due = pixel_due.pop_front();
            check_channel("red",   rsp_red,   due.px.red,   due);
            check_channel("green", rsp_green, due.px.green, due);
            check_channel("blue",  rsp_blue,  due.px.blue,  due);
            checked_count++;
         end
      end
   end

   // register write, setup then access, only while the pipe is empty
   task automatic write_floor(logic [FLOOR_W-1:0] fv);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_FLOOR_DB, 2'b00};
      pwdata  <= {{(CSR_DATA_W - FLOOR_W){fv[FLOOR_W-1]}}, fv};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      floor_setting = fv;
      floor_writes++;
   endtask

   // sender pauses here until every queued level has come back as a pixel
   task automatic drain();
      do @(negedge clock);
      while (level_backlog.size() != 0 || pixel_due.size() != 0 || start);
   endtask

   // random level, mostly spread across the palette span of the current floor
   function automatic logic [LEVEL_W-1:0] random_level(logic [FLOOR_W-1:0] fv);
      int unsigned fmag;
      int unsigned span;
      int          m;
      fmag = fv[FLOOR_W-1] ? (32'h200 - fv) : fv;
      span = (fmag == 0) ? 1 : (fmag << FRAC);
      case ($urandom_range(0, 9))
         0: return LEVEL_W'($urandom);
         1: return LEVEL_W'($urandom_range(0, 32767));
         2: begin
            // straddle the black threshold
            m = int'(span) + int'($urandom_range(0, 6)) - 3;
            if (m < 1) m = 1;
            if (m > 32768) m = 32768;
            return LEVEL_W'(-m);
         end
         default: return LEVEL_W'(-int'($urandom_range(1, span)));
      endcase
   endfunction

   initial begin
      logic [FLOOR_W-1:0] fv;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, under the reset floor of -90 dB: white side, both ends, black threshold
      level_backlog = '{16'sd0, 16'sd1, 16'sd32767, -16'sd1, -16'sd64, -16'sd640,
                        -16'sd641, -16'sd5760, -16'sd11519, -16'sd11520, -16'sd11521,
                        -16'sd32768};
      drain();
      // zero floor: anything negative is black, zero still white
      write_floor(9'd0);
      level_backlog = '{-16'sd1, -16'sd32768, 16'sd0};
      drain();
      // most negative floor spans the full level range
      write_floor(9'h100);
      level_backlog = '{-16'sd32768, -16'sd32767, -16'sd1};
      drain();
      // positive floor acts as its magnitude
      write_floor(9'd255);
      level_backlog = '{-16'sd32767, -16'sd12345};
      drain();
      // narrowest floor, -1 dB
      write_floor(-9'sd1);
      level_backlog = '{-16'sd1, -16'sd7, -16'sd127, -16'sd128};
      drain();

      // random phases: floor, sender idle share, two bursts with a full drain between
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: fv = -9'sd90;
            1: fv = -9'sd180;
            2: fv = -9'sd1;
            3: fv = FLOOR_W'(-int'($urandom_range(1, 180)));
            4: fv = FLOOR_W'($urandom);
            5: fv = -9'sd45;
            6: fv = 9'd90;
            default: fv = FLOOR_W'(-int'($urandom_range(1, 180)));
         endcase
         write_floor(fv);
         case (ph % 4)
            0: send_idle_pct = 0;
            1: send_idle_pct = 50;
            2: send_idle_pct = 0;
            default: send_idle_pct = 27;
         endcase
         for (int burst = 0; burst < 2; burst++) begin
            for (int i = 0; i < 68; i++)
               level_backlog.push_back(random_level(floor_setting));
            drain();
         end
      end

      // let any stray strobe show up before the verdict
      repeat (PIPE_LATENCY + 4) @(negedge clock);
      $display("summary: %0d levels sent, %0d pixels checked over %0d floor writes",
               sent_count, checked_count, floor_writes);
      $display("summary: floors included zero, positive, -1, -180 and -256 dB");
      if (mismatch_count == 0 && pixel_due.size() == 0) begin
         $display("tb_db_to_rgb_colour_map: clean");
      end else begin
         $display("tb_db_to_rgb_colour_map: errors");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #400000;
      $display("timeout waiting for pixels");
      $display("tb_db_to_rgb_colour_map: errors");
      $finish;
   end

endmodule
